>>> rtl/core/b64e_pkg.sv
// b64e_pkg: shared types, constants and the sextet-to-ASCII map for the
// Base64 stream encoder. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package b64e_pkg;

	localparam int QueueDepth = 2;
	localparam logic [7:0] PAD_CHAR = 8'h3D;
	localparam int MaxChars = 4;

	// One accepted byte turned into up to four characters.
	typedef struct packed {
		logic [MaxChars-1:0][7:0] chars;
		logic [1:0]               cnt_m1;   // number of chars minus one
		logic                     msg_end;  // last char closes the message
	} job_t;

	function automatic logic [7:0] sextet_char(input logic [5:0] v);
		logic [7:0] w;
		logic [7:0] r;
		w = {2'b00, v};
		if (v < 6'd26) begin
			r = 8'h41 + w;
		end else if (v < 6'd52) begin
			r = 8'h61 + (w - 8'd26);
		end else if (v < 6'd62) begin
			r = 8'h30 + (w - 8'd52);
		end else if (v == 6'd62) begin
			r = 8'h2B;
		end else begin
			r = 8'h2F;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/b64e_ifs.sv
// b64e_ifs: valid/ready channel interfaces for the byte input and the
// character output of the Base64 encoder. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface b64e_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       last_byte;

	modport source(output valid, output in_byte, output last_byte, input ready);
	modport sink(input valid, input in_byte, input last_byte, output ready);
endinterface

interface b64e_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       run_last;
	logic       message_end;

	modport source(output valid, output out_char, output run_last, output message_end,
		input ready);
	modport sink(input valid, input out_char, input run_last, input message_end,
		output ready);
endinterface

`default_nettype wire

>>> rtl/core/base64_stream_encoder_top.sv
// base64_stream_encoder_top: Base64 (standard alphabet, '=' padding) stream
// encoder. Depends on b64e_pkg, b64e_ifs, b64e_front, b64e_queue, b64e_back.
//
// Usage:
//   byte_ch (sink): one raw byte per beat, last_byte marks the final byte of
//   a message. char_ch (source): one ASCII character per beat; run_last marks
//   the last character a byte produced, message_end the final character of
//   the encoded message (padded to a multiple of four).
// Path: an accepted beat's job is written into the job queue, then its
//   characters are loaded from the queue head into the output register.
// Throughput: one character per cycle while char_ch is ready and jobs wait;
//   a byte yields one to four characters (4/3 on average mid-message). The
//   input takes a beat every cycle while the job queue (QUEUE_DEPTH entries) has room.
// Reset: arst_n clears phase and leftover bits, empties the queue and drops
//   the output valid; byte_ch.ready is already high during reset (queue empty).
// Stall: when char_ch.ready is low a valid output register holds; jobs pile up
//   in the queue and byte_ch.ready falls once it is full.
`timescale 1ns / 1ps
`default_nettype none

module base64_stream_encoder_top #(
	parameter int QUEUE_DEPTH = b64e_pkg::QueueDepth
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	b64e_byte_if.sink    byte_ch,
	b64e_char_if.source  char_ch
);

	logic           push;
	logic           pop;
	logic           full;
	logic           empty;
	b64e_pkg::job_t push_job;
	b64e_pkg::job_t head;

	b64e_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_ch  (byte_ch),
		.push     (push),
		.push_job (push_job),
		.full     (full)
	);

	b64e_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (full),
		.pop      (pop),
		.head     (head),
		.empty    (empty)
	);

	b64e_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.empty   (empty),
		.pop     (pop),
		.char_ch (char_ch)
	);

endmodule

`default_nettype wire

>>> rtl/core/b64e_front.sv
// b64e_front: accepts byte beats, tracks phase and leftover bits, and builds
// one job (up to four characters) per byte. Depends on b64e_pkg, b64e_ifs.
`timescale 1ns / 1ps
`default_nettype none

module b64e_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	b64e_byte_if.sink          byte_ch,
	output logic               push,
	output b64e_pkg::job_t     push_job,
	input  wire logic          full
);

	localparam logic [1:0] PH_0 = 2'd0;
	localparam logic [1:0] PH_1 = 2'd1;
	localparam logic [1:0] PH_2 = 2'd2;

	logic [1:0] phase_q;
	logic [5:0] carry_q;
	logic [1:0] phase_nx;
	logic [5:0] carry_nx;
	logic [7:0] b;
	b64e_pkg::job_t job;

	assign b = byte_ch.in_byte;
	assign byte_ch.ready = !full;
	assign push = byte_ch.valid && !full;

	always_comb begin
		job = '0;
		case (phase_q)
			PH_1: begin
				job.chars[0] = b64e_pkg::sextet_char(carry_q | {2'b00, b[7:4]});
				job.cnt_m1   = 2'd0;
				carry_nx     = {b[3:0], 2'b00};
				phase_nx     = PH_2;
			end
			PH_2: begin
				job.chars[0] = b64e_pkg::sextet_char(carry_q | {4'b0000, b[7:6]});
				job.chars[1] = b64e_pkg::sextet_char(b[5:0]);
				job.cnt_m1   = 2'd1;
				carry_nx     = 6'd0;
				phase_nx     = PH_0;
			end
			default: begin
				// unused phase code behaves as phase 0
				job.chars[0] = b64e_pkg::sextet_char(b[7:2]);
				job.cnt_m1   = 2'd0;
				carry_nx     = {b[1:0], 4'b0000};
				phase_nx     = PH_1;
			end
		endcase

		if (byte_ch.last_byte) begin
			job.msg_end = 1'b1;
			// after a single char, flush leftover bits and pad; two-char jobs need neither
			if (phase_nx == PH_1) begin
				job.chars[1] = b64e_pkg::sextet_char(carry_nx);
				job.chars[2] = b64e_pkg::PAD_CHAR;
				job.chars[3] = b64e_pkg::PAD_CHAR;
				job.cnt_m1   = 2'd3;
			end else if (phase_nx == PH_2) begin
				job.chars[1] = b64e_pkg::sextet_char(carry_nx);
				job.chars[2] = b64e_pkg::PAD_CHAR;
				job.cnt_m1   = 2'd2;
			end
			phase_nx = PH_0;
			carry_nx = 6'd0;
		end
	end

	assign push_job = job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_0;
			carry_q <= 6'd0;
		end else if (push) begin
			phase_q <= phase_nx;
			carry_q <= carry_nx;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/b64e_queue.sv
// b64e_queue: small FIFO of jobs between the front and back of the encoder;
// head is shown combinationally. Depends on b64e_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b64e_queue #(
	parameter int DEPTH = b64e_pkg::QueueDepth
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire b64e_pkg::job_t  push_job,
	output logic                 full,
	input  wire logic            pop,
	output b64e_pkg::job_t       head,
	output logic                 empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	b64e_pkg::job_t mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full  = (count_q == FULL_CNT);
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("queue push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("queue pop while empty");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("queue count beyond depth");

endmodule

`default_nettype wire

>>> rtl/core/b64e_back.sv
// b64e_back: walks the head job one character per cycle (output slot free) into the output
// register and pops the job after its last character. Depends on b64e_pkg, b64e_ifs.
`timescale 1ns / 1ps
`default_nettype none

module b64e_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire b64e_pkg::job_t  head,
	input  wire logic            empty,
	output logic                 pop,
	b64e_char_if.source          char_ch
);

	logic [1:0] idx_q;
	logic       out_v_q;
	logic [7:0] char_q;
	logic       run_last_q;
	logic       msg_end_q;
	logic       slot_free;
	logic       take;
	logic       is_final;

	assign slot_free = !out_v_q || char_ch.ready;
	assign take      = slot_free && !empty;
	assign is_final  = (idx_q == head.cnt_m1);
	assign pop       = take && is_final;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= 2'd0;
			out_v_q <= 1'b0;
		end else begin
			if (slot_free) begin
				out_v_q <= !empty;
			end
			if (take) begin
				idx_q <= is_final ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			char_q     <= head.chars[idx_q];
			run_last_q <= is_final;
			msg_end_q  <= is_final && head.msg_end;
		end
	end

	assign char_ch.valid       = out_v_q;
	assign char_ch.out_char    = char_q;
	assign char_ch.run_last    = run_last_q;
	assign char_ch.message_end = msg_end_q;

	a_end_is_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && msg_end_q) |-> run_last_q)
		else $error("message end without run end");

	a_idx_needs_job: assert property (@(posedge clk) disable iff (!arst_n)
		(idx_q != 2'd0) |-> !empty)
		else $error("mid-job index with no job queued");

	a_idx_in_job: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (idx_q <= head.cnt_m1))
		else $error("char index past job length");

endmodule

`default_nettype wire
